[sv/fadc_word_stream_encoder_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef FADC_WORD_STREAM_ENCODER_TOP_MACROS_SVH
`define FADC_WORD_STREAM_ENCODER_TOP_MACROS_SVH

// Property checked only while reset is released.
`define FWSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define FWSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/fwse_pkg.sv]
package fwse_pkg;

    localparam int TS_W       = 27;
    localparam int SMP_W      = 13;
    localparam int LOW_W      = 12;
    localparam int NUM_SMP    = 4;
    localparam int CNT_W      = 8;
    localparam int BOARD_W    = 8;
    localparam int CODE_W     = 4;
    localparam int VALUE_W    = 27;
    localparam int WIDTH_W    = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CNT_W-1:0]   RUN_MAX      = 8'd255;
    localparam logic [BOARD_W-1:0] HALVE_LIMIT  = 8'd128;
    localparam logic signed [SMP_W:0] DIFF_LIMIT = 14'sd7;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_TS     = 2'd0;
    localparam logic [1:0] OP_FLUSH  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // Record widths.
    localparam logic [WIDTH_W-1:0] RW_ADC   = 5'd1;
    localparam logic [WIDTH_W-1:0] RW_CODE  = 5'd4;
    localparam logic [WIDTH_W-1:0] RW_COUNT = 5'd8;
    localparam logic [WIDTH_W-1:0] RW_SMP   = 5'd13;
    localparam logic [WIDTH_W-1:0] RW_TS    = 5'd27;

    // One queued job: either a finished run or a coded sample word.
    typedef struct packed {
        logic                              is_run;
        logic                              run_adc;
        logic [TS_W-1:0]                   run_start;
        logic [CNT_W-1:0]                  run_count;
        logic [NUM_SMP-1:0][SMP_W-1:0]     smp;
        logic [NUM_SMP-1:0]                short_code;
        logic [NUM_SMP-1:0][CODE_W-1:0]    code;
    } job_t;

endpackage

[sv/fwse_queue.sv]
module fwse_queue #(
    parameter int DEPTH = fwse_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fwse_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output fwse_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fwse_pkg::job_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/fwse_front.sv]
module fwse_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [fwse_pkg::BOARD_W-1:0] cfg_data,
    input  logic                         accept,
    input  logic [1:0]                   opcode,
    input  logic                         adc_select,
    input  logic [fwse_pkg::TS_W-1:0]    raw_timestamp,
    input  logic [fwse_pkg::NUM_SMP-1:0] overflow_bits,
    input  logic [fwse_pkg::NUM_SMP*fwse_pkg::LOW_W-1:0] sample_bytes,
    output logic                         push,
    output fwse_pkg::job_t               push_job
);

    localparam int TS_W  = fwse_pkg::TS_W;
    localparam int SMP_W = fwse_pkg::SMP_W;
    localparam int LOW_W = fwse_pkg::LOW_W;
    localparam int CNT_W = fwse_pkg::CNT_W;
    localparam int NSMP  = fwse_pkg::NUM_SMP;

    logic [fwse_pkg::BOARD_W-1:0] board_reg;
    logic                 open_reg, open_next;
    logic                 island_adc_reg, island_adc_next;
    logic [TS_W-1:0]      island_start_reg, island_start_next;
    logic [CNT_W-1:0]     run_count_reg, run_count_next;
    logic [TS_W-1:0]      prev_time_reg, prev_time_next;
    logic                 prev_adc_reg, prev_adc_next;
    logic [SMP_W-1:0]     prev_sample_reg, prev_sample_next;

    logic [TS_W-1:0]      ts_eff;
    logic                 new_run;
    logic [NSMP-1:0][SMP_W-1:0] smp;
    logic [SMP_W-1:0]     pred [NSMP];
    logic signed [SMP_W:0] diff [NSMP];

    always_comb begin
        ts_eff = (board_reg < fwse_pkg::HALVE_LIMIT) ? {1'b0, raw_timestamp[TS_W-1:1]}
                                                     : raw_timestamp;
        new_run = !open_reg
               || ({1'b0, ts_eff} != ({1'b0, prev_time_reg} + (TS_W+1)'(1)))
               || (adc_select != prev_adc_reg)
               || (run_count_reg == fwse_pkg::RUN_MAX);
    end

    // Every sample after the first is predicted by its neighbor in the same word,
    // so the four differences are independent of each other.
    always_comb begin
        for (int k = 0; k < NSMP; k++) begin
            smp[k]  = {overflow_bits[k], sample_bytes[k*LOW_W +: LOW_W]};
            pred[k] = (k == 0) ? prev_sample_reg : smp[(k == 0) ? 0 : k-1];
            diff[k] = $signed({1'b0, smp[k]}) - $signed({1'b0, pred[k]});
        end
    end

    always_comb begin
        push_job           = '0;
        push_job.run_adc   = island_adc_reg;
        push_job.run_start = island_start_reg;
        push_job.run_count = run_count_reg;
        push_job.is_run    = (opcode != fwse_pkg::OP_SAMPLE);
        push_job.smp       = smp;
        for (int k = 0; k < NSMP; k++) begin
            push_job.short_code[k] = (diff[k] <= fwse_pkg::DIFF_LIMIT)
                                  && (diff[k] >= -fwse_pkg::DIFF_LIMIT);
            push_job.code[k]  = diff[k][3:0] + 4'd8;
        end

        push              = 1'b0;
        open_next         = open_reg;
        island_adc_next   = island_adc_reg;
        island_start_next = island_start_reg;
        run_count_next    = run_count_reg;
        prev_time_next    = prev_time_reg;
        prev_adc_next     = prev_adc_reg;
        prev_sample_next  = prev_sample_reg;

        if (accept) begin
            case (opcode)
                fwse_pkg::OP_TS: begin
                    push = new_run && open_reg;
                    if (new_run) begin
                        open_next         = 1'b1;
                        island_adc_next   = adc_select;
                        island_start_next = ts_eff;
                        run_count_next    = CNT_W'(1);
                    end else begin
                        run_count_next = run_count_reg + 1'b1;
                    end
                    prev_adc_next  = adc_select;
                    prev_time_next = ts_eff;
                end
                fwse_pkg::OP_FLUSH: begin
                    push              = open_reg;
                    open_next         = 1'b0;
                    island_adc_next   = 1'b0;
                    island_start_next = '0;
                    run_count_next    = '0;
                    prev_time_next    = '0;
                    prev_adc_next     = 1'b0;
                    prev_sample_next  = '0;
                end
                fwse_pkg::OP_SAMPLE: begin
                    push             = 1'b1;
                    prev_sample_next = smp[NSMP-1];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_reg        <= '0;
            open_reg         <= 1'b0;
            island_adc_reg   <= 1'b0;
            island_start_reg <= '0;
            run_count_reg    <= '0;
            prev_time_reg    <= '0;
            prev_adc_reg     <= 1'b0;
            prev_sample_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                board_reg <= cfg_data;
            end
            open_reg         <= open_next;
            island_adc_reg   <= island_adc_next;
            island_start_reg <= island_start_next;
            run_count_reg    <= run_count_next;
            prev_time_reg    <= prev_time_next;
            prev_adc_reg     <= prev_adc_next;
            prev_sample_reg  <= prev_sample_next;
        end
    end

endmodule

[sv/fwse_back.sv]
module fwse_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  fwse_pkg::job_t               head_job,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fwse_pkg::VALUE_W-1:0] code_value,
    output logic [fwse_pkg::WIDTH_W-1:0] code_width,
    output logic                         last_of_item
);

    localparam int VALUE_W = fwse_pkg::VALUE_W;

    fwse_pkg::job_t job_reg;
    logic           job_valid_reg, job_valid_next;
    logic [1:0]     rstep_reg, rstep_next;
    logic [1:0]     k_reg, k_next;
    logic           phase_reg, phase_next;

    logic                         out_valid_reg;
    logic [VALUE_W-1:0]           value_reg;
    logic [fwse_pkg::WIDTH_W-1:0] width_reg;
    logic                         last_reg;

    logic [VALUE_W-1:0]           rec_value;
    logic [fwse_pkg::WIDTH_W-1:0] rec_width;
    logic                         rec_last;
    logic                         smp_done;
    logic                         out_free, fire;

    // Record selected by the current step of the job in hand.
    always_comb begin
        smp_done = 1'b0;
        if (job_reg.is_run) begin
            case (rstep_reg)
                2'd0: begin
                    rec_value = VALUE_W'(job_reg.run_adc);
                    rec_width = fwse_pkg::RW_ADC;
                end
                2'd1: begin
                    rec_value = job_reg.run_start;
                    rec_width = fwse_pkg::RW_TS;
                end
                default: begin
                    rec_value = VALUE_W'(job_reg.run_count);
                    rec_width = fwse_pkg::RW_COUNT;
                end
            endcase
            rec_last = (rstep_reg == 2'd2);
        end else begin
            if (job_reg.short_code[k_reg] && !phase_reg) begin
                rec_value = VALUE_W'(job_reg.code[k_reg]);
                rec_width = fwse_pkg::RW_CODE;
                smp_done  = 1'b1;
            end else if (!phase_reg) begin
                // Escape code ahead of a verbatim sample.
                rec_value = '0;
                rec_width = fwse_pkg::RW_CODE;
            end else begin
                rec_value = VALUE_W'(job_reg.smp[k_reg]);
                rec_width = fwse_pkg::RW_SMP;
                smp_done  = 1'b1;
            end
            rec_last = smp_done && (k_reg == 2'd3);
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = job_valid_reg && out_free;
    assign pop      = head_valid && (!job_valid_reg || (fire && rec_last));

    always_comb begin
        job_valid_next = job_valid_reg;
        rstep_next     = rstep_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        if (pop) begin
            job_valid_next = 1'b1;
            rstep_next     = '0;
            k_next         = '0;
            phase_next     = 1'b0;
        end else if (fire) begin
            if (rec_last) begin
                job_valid_next = 1'b0;
            end else if (job_reg.is_run) begin
                rstep_next = rstep_reg + 1'b1;
            end else if (smp_done) begin
                k_next     = k_reg + 1'b1;
                phase_next = 1'b0;
            end else begin
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            rstep_reg     <= '0;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            rstep_reg     <= rstep_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            if (out_free) begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
        end
        if (fire) begin
            value_reg <= rec_value;
            width_reg <= rec_width;
            last_reg  <= rec_last;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign code_value   = value_reg;
    assign code_width   = width_reg;
    assign last_of_item = last_reg;

endmodule

[sv/fadc_word_stream_encoder_top.sv]
// Flash-ADC word stream encoder.
// Input stream (s_*): s_tuser carries the opcode (timestamp word, flush, sample
// word); s_tdata carries the 80-bit word fields. Configuration channel (cfg_*)
// writes board_number; it is always ready and must only be used while idle.
// Output stream (m_*): one record per transaction, value and bit width in
// m_tdata, m_tlast on the final record produced by an input item.
// A front stage updates the run and sample predictors and posts at most one job
// per item into a small job queue; a back stage expands each job into records,
// one record per cycle while m_tready allows. Timestamp words are accepted
// every cycle while the queue has room; a closed run gives 3 records and a
// sample word 4 to 8, so the output channel sets the sustained rate. With an
// empty queue an item's first record passes the queue, job and output registers.
// A stalled receiver holds the output register; the queue then fills and
// s_tready drops once it holds QUEUE_DEPTH jobs.
// Reset clears board_number, all predictors, the queue and the output valid.
module fadc_word_stream_encoder_top #(
    parameter int QUEUE_DEPTH = fwse_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // board_number
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,       // adc_select, raw_timestamp, overflow_bits, sample_bytes
    input  logic [1:0]  s_tuser,       // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // code_value, code_width
    output logic        m_tlast
);

    logic           accept;
    logic           push, full, pop, head_valid;
    fwse_pkg::job_t push_job, head_job;
    logic [fwse_pkg::VALUE_W-1:0] code_value;
    logic [fwse_pkg::WIDTH_W-1:0] code_width;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;

    fwse_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .opcode        (s_tuser),
        .adc_select    (s_tdata[0]),
        .raw_timestamp (s_tdata[27:1]),
        .overflow_bits (s_tdata[31:28]),
        .sample_bytes  (s_tdata[79:32]),
        .push          (push),
        .push_job      (push_job)
    );

    fwse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    fwse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .code_value   (code_value),
        .code_width   (code_width),
        .last_of_item (m_tlast)
    );

    assign m_tdata = {code_width, code_value};

endmodule

[sv/fwse_chk.sv]
`include "fadc_word_stream_encoder_top_macros.svh"

module fwse_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    logic [4:0]  rec_width;
    logic [32:0] rec_word;
    logic        out_stall;
    logic        width_ok;
    logic        run_mark_ok;

    assign rec_width = m_tdata[31:27];
    assign rec_word  = {m_tlast, m_tdata};
    assign out_stall = m_tvalid && !m_tready;
    assign width_ok  = (rec_width == fwse_pkg::RW_ADC) || (rec_width == fwse_pkg::RW_CODE)
                    || (rec_width == fwse_pkg::RW_COUNT) || (rec_width == fwse_pkg::RW_SMP)
                    || (rec_width == fwse_pkg::RW_TS);
    assign run_mark_ok = ((rec_width == fwse_pkg::RW_COUNT) == m_tlast)
                      || (rec_width == fwse_pkg::RW_CODE) || (rec_width == fwse_pkg::RW_SMP);

    // A stalled record must hold.
    `FWSE_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable(rec_word), "stalled record changed")

    // Only the five record widths exist.
    `FWSE_ASSERT(a_width_legal, aclk, aresetn, m_tvalid |-> width_ok, "illegal record width")

    // A run closes with its count record, and its adc bit record never ends an item.
    `FWSE_ASSERT(a_run_last, aclk, aresetn, m_tvalid |-> run_mark_ok, "run record marked wrong")

    // No record is offered right after reset.
    `FWSE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind fadc_word_stream_encoder_top fwse_chk u_fwse_chk (.*);

[bench/tb_fadc_word_stream_encoder_top.sv]
module tb_fadc_word_stream_encoder_top;
    import fwse_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;      // undefined opcode, the block ignores it
    localparam int IDLE_PCT      = 13;
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_LIMIT    = 2000;
    localparam int ESCAPE_CODE   = 0;
    localparam int CODE_BIAS     = 8;
    localparam int ITEMS_PER_SET = 5;

    typedef struct {
        logic [1:0]         op;
        logic               adc;
        logic [TS_W-1:0]    ts;
        logic [3:0]         ovf;
        logic [47:0]        sb;
    } fadc_word_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
        logic               last;
    } code_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    fadc_word_stream_encoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    fadc_word_t pending_words[$];
    code_rec_t  expected_codes[$];

    // Mirror of the block's register and predictor state.
    logic [BOARD_W-1:0] board_cfg = '0;
    logic               run_open;
    logic               run_adc;
    logic [TS_W-1:0]    run_start;
    logic [CNT_W-1:0]   run_len;
    logic [TS_W-1:0]    last_ts;
    logic               prev_ts_adc;
    logic [SMP_W-1:0]   smp_prev;

    logic [SMP_W-1:0]   gen_smp;
    logic               steady = 1'b0;
    logic               s_taken = 1'b0;
    int                 error_count = 0;
    int                 idle_cycles = 0;
    int                 words_in = 0;
    int                 flushes_in = 0;
    int                 sample_words_in = 0;
    int                 records_out = 0;
    int                 board_writes = 0;
    fadc_word_t         next_word;
    fadc_word_t         seen_word;
    code_rec_t          want;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void clear_state();
        run_open    = 1'b0;
        run_adc     = 1'b0;
        run_start   = '0;
        run_len     = '0;
        last_ts     = '0;
        prev_ts_adc = 1'b0;
        smp_prev    = '0;
    endfunction

    function automatic void push_code(input int value, input logic [WIDTH_W-1:0] width);
        code_rec_t r;
        r.value = VALUE_W'(value);
        r.width = width;
        r.last  = 1'b0;
        expected_codes.push_back(r);
    endfunction

    function automatic void close_run();
        push_code(int'(run_adc), RW_ADC);
        push_code(int'(run_start), RW_TS);
        push_code(int'(run_len), RW_COUNT);
    endfunction

    // Works out the records that one accepted word causes and queues them.
    function automatic void encode_word(input fadc_word_t w);
        int               first;
        int               d;
        logic [TS_W-1:0]  t;
        logic [SMP_W-1:0] s;
        code_rec_t        r;
        first = expected_codes.size();
        case (w.op)
            OP_TS: begin
                t = (board_cfg < HALVE_LIMIT) ? (w.ts >> 1) : w.ts;
                if (!run_open || {1'b0, t} != {1'b0, last_ts} + 28'd1 ||
                    w.adc != prev_ts_adc || run_len == RUN_MAX) begin
                    if (run_open)
                        close_run();
                    run_open  = 1'b1;
                    run_adc   = w.adc;
                    run_start = t;
                    run_len   = '0;
                end
                prev_ts_adc = w.adc;
                last_ts     = t;
                run_len     = run_len + 8'd1;
            end
            OP_FLUSH: begin
                if (run_open)
                    close_run();
                clear_state();
            end
            OP_SAMPLE: begin
                for (int k = 0; k < NUM_SMP; k++) begin
                    s = {w.ovf[k], w.sb[LOW_W*k +: LOW_W]};
                    d = int'(s) - int'(smp_prev);
                    smp_prev = s;
                    if (d <= int'(DIFF_LIMIT) && d >= -int'(DIFF_LIMIT)) begin
                        push_code(d + CODE_BIAS, RW_CODE);
                    end else begin
                        push_code(ESCAPE_CODE, RW_CODE);
                        push_code(int'(s), RW_SMP);
                    end
                end
            end
            default: ;
        endcase
        if (expected_codes.size() > first) begin
            r = expected_codes.pop_back();
            r.last = 1'b1;
            expected_codes.push_back(r);
        end
    endfunction

    function automatic fadc_word_t random_word(input logic [1:0] op);
        fadc_word_t w;
        w.op  = op;
        w.adc = 1'($urandom_range(1));
        w.ts  = TS_W'($urandom());
        w.ovf = 4'($urandom());
        w.sb  = 48'({$urandom(), $urandom()});
        return w;
    endfunction

    // Timestamp word whose value after optional halving is t.
    function automatic fadc_word_t ts_word(input logic adc, input logic [TS_W-1:0] t);
        fadc_word_t w;
        w = random_word(OP_TS);
        w.adc = adc;
        w.ts = (board_cfg < HALVE_LIMIT) ? {t[TS_W-2:0], 1'($urandom_range(1))} : t;
        return w;
    endfunction

    function automatic fadc_word_t sample_word(input logic [47:0] sb, input logic [3:0] ovf);
        fadc_word_t w;
        w = random_word(OP_SAMPLE);
        w.sb  = sb;
        w.ovf = ovf;
        return w;
    endfunction

    // Sample word that mostly stays near the running sample, so most codes are short.
    function automatic fadc_word_t coded_sample_word();
        fadc_word_t       w;
        int               mode;
        int               v;
        logic [SMP_W-1:0] s;
        w = random_word(OP_SAMPLE);
        for (int k = 0; k < NUM_SMP; k++) begin
            mode = $urandom_range(99);
            if (mode < 65)
                v = int'(gen_smp) + $urandom_range(14) - 7;
            else if (mode < 80)
                v = int'(gen_smp) + ($urandom_range(1) ? 8 : -8);
            else
                v = -1;
            if (v < 0 || v > 8191)
                s = SMP_W'($urandom());
            else
                s = SMP_W'(v);
            gen_smp = s;
            w.ovf[k] = s[SMP_W-1];
            w.sb[LOW_W*k +: LOW_W] = s[LOW_W-1:0];
        end
        return w;
    endfunction

    task automatic queue_random_set(input int n);
        int              count;
        int              sel;
        int              len;
        logic            adc;
        logic [TS_W-1:0] t;
        logic [TS_W-1:0] span;
        fadc_word_t      w;
        count = 0;
        span = (board_cfg < HALVE_LIMIT) ? TS_W'(27'h3FF_FFFF) : TS_W'(27'h7FF_FFFF);
        while (count < n) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                len = $urandom_range(1, 12);
                adc = 1'($urandom_range(1));
                t = ($urandom_range(4) == 0) ? span - 3 : TS_W'($urandom()) & span;
                for (int i = 0; i < len; i++) begin
                    pending_words.push_back(ts_word(adc, t));
                    count++;
                    sel = $urandom_range(9);
                    if (sel == 0)
                        adc = ~adc;
                    if (sel == 1)
                        t = TS_W'($urandom()) & span;
                    else
                        t = (t + TS_W'(1)) & span;
                end
                if ($urandom_range(9) > 0) begin
                    pending_words.push_back(random_word(OP_FLUSH));
                    gen_smp = '0;
                    count++;
                end
            end else if (sel < 85) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    pending_words.push_back(coded_sample_word());
                    count++;
                end
                if ($urandom_range(9) < 3) begin
                    pending_words.push_back(random_word(OP_FLUSH));
                    gen_smp = '0;
                    count++;
                end
            end else begin
                sel = $urandom_range(3);
                w = random_word(sel == 0 ? OP_TS : sel == 1 ? OP_FLUSH :
                                sel == 2 ? OP_SAMPLE : OP_NONE);
                pending_words.push_back(w);
                if (w.op != OP_NONE)
                    count++;
            end
        end
    endtask

    task automatic write_board(input logic [BOARD_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board_cfg = value;
        board_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || s_tvalid || expected_codes.size() > 0)
            @(posedge aclk);
        // A trailing word with no records may still be in the block.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Input driver: presents the next pending word once the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_words.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_word.op;
                s_tdata  <= {next_word.sb, next_word.ovf, next_word.ts, next_word.adc};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: checks each record and predicts from each accepted word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
            idle_cycles <= 0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                records_out++;
                if (expected_codes.size() == 0) begin
                    report_error($sformatf("record %h last %b with nothing expected",
                                           m_tdata, m_tlast));
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.value)
                        report_error($sformatf("code value %h, expected %h",
                                               m_tdata[VALUE_W-1:0], want.value));
                    if (m_tdata[31:VALUE_W] !== want.width)
                        report_error($sformatf("code width %0d, expected %0d",
                                               m_tdata[31:VALUE_W], want.width));
                    if (m_tlast !== want.last)
                        report_error($sformatf("last flag %b, expected %b",
                                               m_tlast, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                seen_word.op  = s_tuser;
                seen_word.adc = s_tdata[0];
                seen_word.ts  = s_tdata[TS_W:1];
                seen_word.ovf = s_tdata[31:28];
                seen_word.sb  = s_tdata[79:32];
                encode_word(seen_word);
                words_in++;
                if (s_tuser == OP_FLUSH)
                    flushes_in++;
                if (s_tuser == OP_SAMPLE)
                    sample_words_in++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Run stalled for %0d cycles.", idle_cycles);
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    logic [BOARD_W-1:0] board_plan[6];

    initial begin
        clear_state();
        gen_smp = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Halving on: run boundaries, flush handling and sample code limits.
        write_board(8'd0);
        pending_words.push_back(random_word(OP_NONE));
        pending_words.push_back(random_word(OP_FLUSH));
        pending_words.push_back(ts_word(1'b0, 27'd0));
        pending_words.push_back(ts_word(1'b0, 27'd1));
        pending_words.push_back(ts_word(1'b0, 27'd2));
        pending_words.push_back(ts_word(1'b1, 27'd3));
        pending_words.push_back(ts_word(1'b1, 27'h3FF_FFFF));
        pending_words.push_back(sample_word(48'h0, 4'h0));
        pending_words.push_back(sample_word({48{1'b1}}, 4'hF));
        pending_words.push_back(sample_word({12'hFFF, 12'hFF7, 12'hFFF, 12'hFF8}, 4'hF));
        pending_words.push_back(ts_word(1'b1, 27'h3FF_FFFF));
        pending_words.push_back(random_word(OP_NONE));
        pending_words.push_back(random_word(OP_FLUSH));
        pending_words.push_back(sample_word({12'd0, 12'd8, 12'd0, 12'd7}, 4'h0));
        pending_words.push_back(random_word(OP_FLUSH));
        wait_idle();

        // Halving off: wrap of the timestamp and a run that overfills, with no idling.
        write_board(8'd255);
        steady = 1'b1;
        pending_words.push_back(ts_word(1'b0, 27'h7FF_FFFE));
        pending_words.push_back(ts_word(1'b0, 27'h7FF_FFFF));
        pending_words.push_back(ts_word(1'b0, 27'd0));
        pending_words.push_back(random_word(OP_FLUSH));
        for (int i = 0; i < 260; i++)
            pending_words.push_back(ts_word(1'b1, TS_W'(1000 + i)));
        pending_words.push_back(random_word(OP_FLUSH));
        wait_idle();

        board_plan = '{8'd127, 8'd128, 8'd0, 8'd255, 8'($urandom()), 8'($urandom())};
        foreach (board_plan[i]) begin
            write_board(board_plan[i]);
            steady = (i == 2);
            gen_smp = smp_prev;
            queue_random_set(ITEMS_PER_SET);
            wait_idle();
        end
        steady = 1'b0;

        $display("Sent %0d words (%0d flushes, %0d sample words) under %0d board settings.",
                 words_in, flushes_in, sample_words_in, board_writes);
        $display("Checked %0d code records, %0d errors.", records_out, error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
